[sv/inter_block_byte_delta_codec_assert.svh]
// Assertion macros for the codec's RTL.
`ifndef INTER_BLOCK_BYTE_DELTA_CODEC_ASSERT_SVH
`define INTER_BLOCK_BYTE_DELTA_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ibbd_pkg.sv]
`timescale 1ns / 1ps
package ibbd_pkg;

    localparam int MAX_BLOCK = 4096;
    localparam int POS_W     = $clog2(MAX_BLOCK + 1);
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int MEM_AW    = ADDR_W + 1;
    localparam int BYTE_W    = 8;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [MEM_AW-1:0] t_mem_addr;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic  opcode;
        t_byte data_byte;
        logic  last_byte;
    } t_in;

    typedef struct packed {
        t_byte out_byte;
        logic  end_of_block;
        logic  overflow;
    } t_out;

    typedef struct packed {
        logic      en;
        t_mem_addr addr;
    } t_mem_rd;

    typedef struct packed {
        logic      en;
        t_mem_addr addr;
        t_byte     data;
    } t_mem_wr;

    typedef struct packed {
        logic      mode;
        logic      have_ref;
        t_byte     data;
        logic      last;
        logic      ovf;
        t_mem_addr waddr;
    } t_s1;

endpackage

[sv/ibbd_ref_mem.sv]
`timescale 1ns / 1ps
module ibbd_ref_mem (
    input  logic             i_clk,
    input  ibbd_pkg::t_mem_rd i_rd,
    output ibbd_pkg::t_byte   o_rd_data,
    input  ibbd_pkg::t_mem_wr i_wr
);
    import ibbd_pkg::*;

    t_byte r_mem [2*MAX_BLOCK];
    t_byte r_q;
    t_byte r_byp_data;
    logic  r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q        <= r_mem[i_rd.addr];
            r_byp      <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;

endmodule

[sv/inter_block_byte_delta_codec.sv]
`timescale 1ns / 1ps
// Inter-block byte delta codec.
// Input channel i_in (valid/stall) carries one byte per request with its
// opcode and end-of-block marker; the opcode is taken from a block's first
// byte. Output channel o_out (valid/stall) returns one coded byte per request
// with end_of_block and overflow flags, in request order.
// An accepted request is registered in stage r_s1 with its reference read,
// and its result is then registered in the output register for o_out; an
// output stall can hold it in stage r_s1. One request is accepted every
// cycle while o_in_stall is low; the rate is set by the reference memory,
// which takes one read and one write per byte. The reference banks are
// one 2 x MAX_BLOCK byte memory with a registered read port; a read that
// meets a same-cycle write of the same entry is served from the write data.
// Reset clears the block position, bank select and reference length, so the
// first block after reset passes through unchanged; memory contents are not
// cleared and no clearing pass is needed.
// When i_out_stall is high the result holds in the output register, one more
// request is taken into stage r_s1 only if it is empty, and o_in_stall is high
// while that stage is full until the output drains.
module inter_block_byte_delta_codec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ibbd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ibbd_pkg::t_out o_out
);
    import ibbd_pkg::*;

    `include "inter_block_byte_delta_codec_assert.svh"

    logic    r_inside;
    logic    r_mode;
    logic    r_bank;
    t_pos    r_ref_len;
    t_pos    r_wp;
    t_addr   r_rp;
    logic    r_s1_valid;
    t_s1     r_s1;
    logic    r_out_valid;
    t_out    r_out;

    logic    in_acc;
    logic    s1_adv;
    logic    first;
    logic    cur_mode;
    t_addr   cur_rp;
    t_pos    cur_wp;
    logic    have_ref;
    t_pos    rp_inc;
    t_addr   n_rp;
    logic    ovf;
    t_pos    wp_inc;
    t_mem_rd mem_rd;
    t_mem_wr mem_wr;
    t_byte   ref_byte;
    t_byte   result;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        first    = !r_inside;
        cur_mode = first ? i_in.opcode : r_mode;
        cur_rp   = first ? '0 : r_rp;
        cur_wp   = first ? '0 : r_wp;
        have_ref = (r_ref_len != '0);
        rp_inc   = t_pos'(cur_rp) + t_pos'(1);
        n_rp     = (rp_inc >= r_ref_len) ? '0 : rp_inc[ADDR_W-1:0];
        ovf      = (cur_wp == t_pos'(MAX_BLOCK));
        wp_inc   = ovf ? cur_wp : cur_wp + t_pos'(1);
    end

    assign mem_rd.en   = in_acc;
    assign mem_rd.addr = {r_bank, cur_rp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside   <= 1'b0;
            r_mode     <= 1'b0;
            r_bank     <= 1'b0;
            r_ref_len  <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_inside   <= !i_in.last_byte;
                r_mode     <= cur_mode;
                r_wp       <= wp_inc;
                r_rp       <= (i_in.last_byte || !have_ref) ? '0 : n_rp;
                r_s1_valid <= 1'b1;
                if (i_in.last_byte) begin
                    r_ref_len <= wp_inc;
                    r_bank    <= ~r_bank;
                end
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.mode     <= cur_mode;
            r_s1.have_ref <= have_ref;
            r_s1.data     <= i_in.data_byte;
            r_s1.last     <= i_in.last_byte;
            r_s1.ovf      <= ovf;
            r_s1.waddr    <= {~r_bank, cur_wp[ADDR_W-1:0]};
        end
    end

    ibbd_ref_mem u_ref_mem (
        .i_clk     (i_clk),
        .i_rd      (mem_rd),
        .o_rd_data (ref_byte),
        .i_wr      (mem_wr)
    );

    always_comb begin
        if (!r_s1.have_ref) begin
            result = r_s1.data;
        end else if (r_s1.mode) begin
            result = r_s1.data + ref_byte;
        end else begin
            result = r_s1.data - ref_byte;
        end
    end

    assign mem_wr.en   = s1_adv && !r_s1.ovf;
    assign mem_wr.addr = r_s1.waddr;
    assign mem_wr.data = r_s1.mode ? result : r_s1.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.out_byte     <= result;
            r_out.end_of_block <= r_s1.last;
            r_out.overflow     <= r_s1.ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `IBBD_ASSERT_NOW(a_ref_len_max, i_clk, i_rst_n, 1'b1,
        r_ref_len <= t_pos'(MAX_BLOCK), "reference length beyond bank size")
    `IBBD_ASSERT_NOW(a_rp_in_ref, i_clk, i_rst_n, r_inside && (r_ref_len != '0),
        t_pos'(r_rp) < r_ref_len, "read position outside reference")
    `IBBD_ASSERT_NOW(a_no_wr_ovf, i_clk, i_rst_n, r_s1_valid && r_s1.ovf,
        !mem_wr.en, "write of an overflow byte")
    `IBBD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && $stable(r_s1), "stalled pipeline stage changed")

endmodule

[tb/inter_block_byte_delta_codec_checker.sv]
`timescale 1ns / 1ps
module inter_block_byte_delta_codec_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  ibbd_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  ibbd_pkg::t_out i_out,
    output int             o_fail_count,
    output int             o_pending
);

    ibbd_pkg::t_byte ref_mem [2][ibbd_pkg::MAX_BLOCK];
    bit              ref_sel;
    int              ref_len;
    int              wr_pos;
    int              rd_pos;
    bit              blk_decode;
    bit              in_block;
    ibbd_pkg::t_out  coded_bytes[$];
    int              errors;

    function automatic ibbd_pkg::t_out code_byte(ibbd_pkg::t_in req);
        ibbd_pkg::t_out  res;
        ibbd_pkg::t_byte ref_byte;
        ibbd_pkg::t_byte plain;
        if (!in_block) begin
            blk_decode = req.opcode;
            in_block   = 1'b1;
            wr_pos     = 0;
            rd_pos     = 0;
        end
        res.out_byte = req.data_byte;
        if (ref_len != 0) begin
            ref_byte = ref_mem[ref_sel][rd_pos];
            rd_pos   = (rd_pos + 1 >= ref_len) ? 0 : rd_pos + 1;
            res.out_byte = blk_decode ? req.data_byte + ref_byte : req.data_byte - ref_byte;
        end
        // The reference always holds the uncoded bytes of the block.
        plain = blk_decode ? res.out_byte : req.data_byte;
        res.overflow = (wr_pos >= ibbd_pkg::MAX_BLOCK);
        if (!res.overflow) begin
            ref_mem[~ref_sel][wr_pos] = plain;
            wr_pos++;
        end
        res.end_of_block = req.last_byte;
        if (req.last_byte) begin
            ref_len  = wr_pos;
            ref_sel  = ~ref_sel;
            in_block = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        ibbd_pkg::t_out want;
        if (!i_rst_n) begin
            ref_sel    = 1'b0;
            ref_len    = 0;
            wr_pos     = 0;
            rd_pos     = 0;
            blk_decode = 1'b0;
            in_block   = 1'b0;
            coded_bytes.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (coded_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_out);
                    errors++;
                end else begin
                    want = coded_bytes.pop_front();
                    if (i_out.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, want.out_byte, i_out.out_byte);
                        errors++;
                    end
                    if (i_out.end_of_block !== want.end_of_block) begin
                        $display("%0t: end_of_block expected %b, actual %b",
                                 $time, want.end_of_block, i_out.end_of_block);
                        errors++;
                    end
                    if (i_out.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %b, actual %b",
                                 $time, want.overflow, i_out.overflow);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                coded_bytes.push_back(code_byte(i_in));
            end
        end
        o_fail_count <= errors;
        o_pending    <= coded_bytes.size();
    end

endmodule

[tb/inter_block_byte_delta_codec_tb.sv]
`timescale 1ns / 1ps
module inter_block_byte_delta_codec_tb;

    localparam logic OP_ENCODE    = 1'b0;
    localparam logic OP_DECODE    = 1'b1;
    localparam int   ITEMS        = 1550;
    localparam int   CYCLE_LIMIT  = 500000;
    localparam int   DRAIN_CYCLES = 8;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    ibbd_pkg::t_in  i_in        = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    ibbd_pkg::t_out o_out;

    int fail_count;
    int pending;
    int cycles;
    int byte_count;
    bit quiet;

    always #5 i_clk = ~i_clk;

    inter_block_byte_delta_codec u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    inter_block_byte_delta_codec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("inter_block_byte_delta_codec: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic op, input ibbd_pkg::t_byte data, input logic last);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 8) ? 1 : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{opcode: op, data_byte: data, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Opcodes after the first byte of a block are random and must be ignored.
    task automatic send_block(input logic op, input int len);
        for (int k = 0; k < len; k++) begin
            send_byte((k == 0) ? op : logic'($urandom_range(0, 1)),
                      ibbd_pkg::t_byte'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first block has no reference and passes through.
        send_byte(OP_ENCODE, 8'h00, 1'b0);
        send_byte(OP_DECODE, 8'hFF, 1'b0);
        send_byte(OP_ENCODE, 8'h80, 1'b1);
        // A block longer than its reference wraps around the reference.
        send_byte(OP_ENCODE, 8'h00, 1'b0);
        send_byte(OP_ENCODE, 8'hFF, 1'b0);
        send_byte(OP_DECODE, 8'h01, 1'b0);
        send_byte(OP_ENCODE, 8'h7F, 1'b0);
        send_byte(OP_ENCODE, 8'h80, 1'b1);
        send_byte(OP_DECODE, 8'hFF, 1'b1);
        send_block(OP_DECODE, 4);
        send_block(OP_ENCODE, 6);
        send_block(OP_DECODE, 2);

        while (byte_count < ITEMS) begin
            quiet = (byte_count >= 500 && byte_count < 900);
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 64);
            send_block(logic'($urandom_range(0, 1)), len);
            byte_count += len;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("inter_block_byte_delta_codec: match");
        end else begin
            $display("inter_block_byte_delta_codec: mismatch");
        end
        $finish;
    end

endmodule
